// File: src/mpw_pkg.sv
// shared types and constants for the masked pixel to world transform
`default_nettype none
package mpw_pkg;

    localparam int unsigned COEF_W      = 32;
    localparam int unsigned DIM_W       = 10;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned NUM_AXES    = 3;
    localparam int unsigned NUM_TERMS   = 3;
    localparam int unsigned NUM_COEF    = NUM_AXES * NUM_TERMS;
    localparam int unsigned MAX_DIM     = 1024;
    localparam int unsigned PROD_W      = COEF_W + DIM_W;
    localparam int unsigned SUM_W       = PROD_W + 2;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned TERM_COL = 0;
    localparam int unsigned TERM_ROW = 1;
    localparam int unsigned TERM_OFF = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic signed [COEF_W-1:0] POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] POS_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic {
        CMD_LOAD,
        CMD_PIXEL
    } cmd_kind_t;

    typedef struct packed {
        logic                       opcode;
        logic [SLOT_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic [DIM_W-1:0]           column;
        logic [DIM_W-1:0]           line;
        logic [LEVEL_W-1:0]         intensity;
        logic                       keep;
    } req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]   pos_x;
        logic signed [COEF_W-1:0]   pos_y;
        logic signed [COEF_W-1:0]   pos_z;
        logic [LEVEL_W-1:0]         level;
        logic signed [COEF_W-1:0]   box_min_x;
        logic signed [COEF_W-1:0]   box_min_y;
        logic signed [COEF_W-1:0]   box_min_z;
        logic signed [COEF_W-1:0]   box_max_x;
        logic signed [COEF_W-1:0]   box_max_y;
        logic signed [COEF_W-1:0]   box_max_z;
    } res_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [COEF_W-1:0]   value;
        logic [DIM_W-1:0]           column;
        logic [DIM_W-1:0]           line;
        logic [LEVEL_W-1:0]         intensity;
    } cmd_t;

endpackage
`default_nettype wire

// File: src/mpw_front.sv
// front end: accepts requests and turns them into queued commands
`default_nettype none
module mpw_front (
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire mpw_pkg::req_t req,
    input  wire logic         queue_full,
    output logic              push_valid,
    output mpw_pkg::cmd_t     push_cmd
);
    import mpw_pkg::*;

    logic is_load;
    logic is_pixel;

    always_comb
    begin
        is_load  = (req.opcode == OP_LOAD) && (32'(req.coef_index) < NUM_COEF);
        is_pixel = (req.opcode == OP_PIXEL) && req.keep
                   && (32'(req.column) < MAX_DIM) && (32'(req.line) < MAX_DIM);
    end

    assign req_ready  = !queue_full;
    assign push_valid = req_valid && req_ready && (is_load || is_pixel);

    always_comb
    begin
        push_cmd.kind      = is_load ? CMD_LOAD : CMD_PIXEL;
        push_cmd.slot      = req.coef_index;
        push_cmd.value     = req.coef_value;
        push_cmd.column    = req.column;
        push_cmd.line      = req.line;
        push_cmd.intensity = req.intensity;
    end

endmodule
`default_nettype wire

// File: src/mpw_queue.sv
// small command queue between front and back ends
`default_nettype none
module mpw_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mpw_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output mpw_pkg::cmd_t      head_cmd
);
    import mpw_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> $stable(wr_ptr_reg))
        else $error("write pointer moved while full");

endmodule
`default_nettype wire

// File: src/mpw_back.sv
// back end: coefficient store, transform pipeline and bounding box
`default_nettype none
module mpw_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          queue_empty,
    input  wire mpw_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               res_valid,
    input  wire logic          res_ready,
    output mpw_pkg::res_t      res
);
    import mpw_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_pc_reg  [NUM_AXES];
    logic signed [PROD_W-1:0] s1_pr_reg  [NUM_AXES];
    logic signed [COEF_W-1:0] s1_off_reg [NUM_AXES];
    logic [LEVEL_W-1:0]       s1_level_reg;

    logic                     s2_valid_reg;
    logic signed [COEF_W-1:0] s2_pos_reg [NUM_AXES];
    logic [LEVEL_W-1:0]       s2_level_reg;

    logic signed [COEF_W-1:0] box_low_reg  [NUM_AXES];
    logic signed [COEF_W-1:0] box_high_reg [NUM_AXES];
    logic signed [COEF_W-1:0] box_low_next  [NUM_AXES];
    logic signed [COEF_W-1:0] box_high_next [NUM_AXES];

    logic                     out_valid_reg;
    res_t                     res_reg;

    logic                     advance;
    logic signed [PROD_W-1:0] pc_next [NUM_AXES];
    logic signed [PROD_W-1:0] pr_next [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_c   [NUM_AXES];
    logic signed [COEF_W-1:0] sat_c   [NUM_AXES];
    logic                     pop_pixel;

    assign advance   = !out_valid_reg || res_ready;
    assign pop       = advance && !queue_empty;
    assign pop_pixel = pop && (head_cmd.kind == CMD_PIXEL);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pc_next[a] = coef_reg[a * NUM_TERMS + TERM_COL]
                         * $signed({1'b0, head_cmd.column});
            pr_next[a] = coef_reg[a * NUM_TERMS + TERM_ROW]
                         * $signed({1'b0, head_cmd.line});
            sum_c[a]   = SUM_W'(s1_pc_reg[a]) + SUM_W'(s1_pr_reg[a])
                         + SUM_W'(s1_off_reg[a]);
            if (sum_c[a][SUM_W-1:COEF_W-1] == '0 || sum_c[a][SUM_W-1:COEF_W-1] == '1)
                sat_c[a] = sum_c[a][COEF_W-1:0];
            else
                sat_c[a] = sum_c[a][SUM_W-1] ? POS_MIN : POS_MAX;
            box_low_next[a]  = (s2_pos_reg[a] < box_low_reg[a])
                               ? s2_pos_reg[a] : box_low_reg[a];
            box_high_next[a] = (s2_pos_reg[a] > box_high_reg[a])
                               ? s2_pos_reg[a] : box_high_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_low_reg[a]  <= POS_MAX;
                box_high_reg[a] <= POS_MIN;
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_COEF; i++)
                if (pop && head_cmd.kind == CMD_LOAD && head_cmd.slot == SLOT_W'(i))
                    coef_reg[i] <= head_cmd.value;
            if (advance)
            begin
                s1_valid_reg  <= pop_pixel;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
                if (s2_valid_reg)
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        box_low_reg[a]  <= box_low_next[a];
                        box_high_reg[a] <= box_high_next[a];
                    end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                s1_pc_reg[a]  <= pc_next[a];
                s1_pr_reg[a]  <= pr_next[a];
                s1_off_reg[a] <= coef_reg[a * NUM_TERMS + TERM_OFF];
                s2_pos_reg[a] <= sat_c[a];
            end
            s1_level_reg <= head_cmd.intensity;
            s2_level_reg <= s1_level_reg;
            if (s2_valid_reg)
            begin
                res_reg.pos_x     <= s2_pos_reg[0];
                res_reg.pos_y     <= s2_pos_reg[1];
                res_reg.pos_z     <= s2_pos_reg[2];
                res_reg.level     <= s2_level_reg;
                res_reg.box_min_x <= box_low_next[0];
                res_reg.box_min_y <= box_low_next[1];
                res_reg.box_min_z <= box_low_next[2];
                res_reg.box_max_x <= box_high_next[0];
                res_reg.box_max_y <= box_high_next[1];
                res_reg.box_max_z <= box_high_next[2];
            end
        end
    end

    a_box_x: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.box_min_x <= res.pos_x) && (res.pos_x <= res.box_max_x))
        else $error("x outside box");

    a_box_y: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.box_min_y <= res.pos_y) && (res.pos_y <= res.box_max_y))
        else $error("y outside box");

    a_box_z: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.box_min_z <= res.pos_z) && (res.pos_z <= res.box_max_z))
        else $error("z outside box");

endmodule
`default_nettype wire

// File: src/masked_pixel_to_world_transform.sv
// masked pixel to world transform: requests pass the queue, then the three-stage pipeline
// throughput one request per cycle while results are taken, set by queue pop and pipeline
// coefficient loads take the same queue slot and produce no result
// reset: coefficients clear to zero, bounding box empties, queue and pipeline drain
// six 32x11 multiplies run in the first stage, sum and saturate in the second, box in the third
`default_nettype none
module masked_pixel_to_world_transform (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mpw_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output mpw_pkg::res_t      res
);
    import mpw_pkg::*;

    logic queue_full;
    logic queue_empty;
    logic push_valid;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    mpw_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    mpw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head_cmd (head_cmd)
    );

    mpw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule
`default_nettype wire

// File: tb/masked_pixel_to_world_transform_test.sv
// testbench for masked_pixel_to_world_transform: point scoreboard, request driver, result checker
`timescale 1ns / 1ps
module masked_pixel_to_world_transform_test;
    import mpw_pkg::*;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;
    localparam int RANDOM_REQUESTS = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    class world_point_board;
        logic signed [COEF_W-1:0] coef [NUM_COEF];
        logic signed [COEF_W-1:0] box_lo [NUM_AXES];
        logic signed [COEF_W-1:0] box_hi [NUM_AXES];
        res_t points_due [$];
        int failures;

        function new();
            foreach (coef[i]) coef[i] = '0;
            foreach (box_lo[i]) box_lo[i] = POS_MAX;
            foreach (box_hi[i]) box_hi[i] = POS_MIN;
            failures = 0;
        endfunction

        function int pending();
            return points_due.size();
        endfunction

        function void note_request(req_t r);
            longint acc;
            logic signed [COEF_W-1:0] pos [NUM_AXES];
            res_t p;
            if (r.opcode == OP_LOAD)
            begin
                if (r.coef_index < NUM_COEF)
                    coef[r.coef_index] = r.coef_value;
                return;
            end
            if (!r.keep || r.column >= MAX_DIM || r.line >= MAX_DIM)
                return;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                acc = longint'(coef[a * NUM_TERMS + TERM_COL]) * longint'(r.column)
                    + longint'(coef[a * NUM_TERMS + TERM_ROW]) * longint'(r.line)
                    + longint'(coef[a * NUM_TERMS + TERM_OFF]);
                if (acc > longint'(POS_MAX))
                    pos[a] = POS_MAX;
                else if (acc < longint'(POS_MIN))
                    pos[a] = POS_MIN;
                else
                    pos[a] = acc[COEF_W-1:0];
                if (pos[a] < box_lo[a])
                    box_lo[a] = pos[a];
                if (pos[a] > box_hi[a])
                    box_hi[a] = pos[a];
            end
            p.pos_x = pos[AXIS_X];
            p.pos_y = pos[AXIS_Y];
            p.pos_z = pos[AXIS_Z];
            p.level = r.intensity;
            p.box_min_x = box_lo[AXIS_X];
            p.box_min_y = box_lo[AXIS_Y];
            p.box_min_z = box_lo[AXIS_Z];
            p.box_max_x = box_hi[AXIS_X];
            p.box_max_y = box_hi[AXIS_Y];
            p.box_max_z = box_hi[AXIS_Z];
            points_due.insert(points_due.size(), p);
        endfunction

        function void compare(string field, logic signed [COEF_W-1:0] want,
                              logic signed [COEF_W-1:0] seen);
            if (want !== seen)
            begin
                failures++;
                $display("%0t: %s expected %0d got %0d", $time, field, want, seen);
            end
        endfunction

        function void check_point(res_t got);
            res_t want;
            if (points_due.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected point, expected none got x %0d y %0d z %0d level %0d",
                         $time, got.pos_x, got.pos_y, got.pos_z, got.level);
                return;
            end
            want = points_due.pop_front();
            compare("pos_x", want.pos_x, got.pos_x);
            compare("pos_y", want.pos_y, got.pos_y);
            compare("pos_z", want.pos_z, got.pos_z);
            compare("level", COEF_W'(want.level), COEF_W'(got.level));
            compare("box_min_x", want.box_min_x, got.box_min_x);
            compare("box_min_y", want.box_min_y, got.box_min_y);
            compare("box_min_z", want.box_min_z, got.box_min_z);
            compare("box_max_x", want.box_max_x, got.box_max_x);
            compare("box_max_y", want.box_max_y, got.box_max_y);
            compare("box_max_z", want.box_max_z, got.box_max_z);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic res_valid;
    logic res_ready;
    res_t res;

    world_point_board board;
    bit no_stall;

    masked_pixel_to_world_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SLOT_W-1:0] coef_slot(int axis, int term);
        return SLOT_W'(axis * NUM_TERMS + term);
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        unique case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return POS_MIN;
            2, 3, 4: return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return DIM_W'($urandom);
        endcase
    endfunction

    function automatic req_t make_load(logic [SLOT_W-1:0] slot, logic signed [COEF_W-1:0] value);
        req_t r;
        r.opcode = OP_LOAD;
        r.coef_index = slot;
        r.coef_value = value;
        r.column = DIM_W'($urandom);
        r.line = DIM_W'($urandom);
        r.intensity = LEVEL_W'($urandom);
        r.keep = 1'($urandom);
        return r;
    endfunction

    function automatic req_t make_pixel(logic [DIM_W-1:0] col, logic [DIM_W-1:0] row,
                                        logic [LEVEL_W-1:0] lvl, logic keep);
        req_t r;
        r.opcode = OP_PIXEL;
        r.coef_index = SLOT_W'($urandom);
        r.coef_value = COEF_W'($urandom);
        r.column = col;
        r.line = row;
        r.intensity = lvl;
        r.keep = keep;
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_request(req_t r, int unsigned gap);
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req = r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_paced(req_t r);
        send_request(r, no_stall ? 0 : idle_gap());
    endtask

    // result side: ready in bursts with random stalls
    initial
    begin
        int unsigned gap;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            res_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            gap = idle_gap();
            if (!no_stall && gap != 0)
            begin
                res_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
                board.check_point(res);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle = 0;
            else
                idle++;
        end
        $display("masked_pixel_to_world_transform: mismatch");
        $finish;
    end

    initial
    begin
        req_t r;
        board = new();
        no_stall = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all coefficients still zero
        send_paced(make_pixel('0, '0, 8'h00, 1'b1));
        // modest coefficients so the box grows gradually
        send_paced(make_load(coef_slot(AXIS_X, TERM_COL), 32'sh0000_8000));
        send_paced(make_load(coef_slot(AXIS_X, TERM_ROW), 32'sh0000_0000));
        send_paced(make_load(coef_slot(AXIS_X, TERM_OFF), -32'sd655360));
        send_paced(make_load(coef_slot(AXIS_Y, TERM_COL), 32'sh0000_0000));
        send_paced(make_load(coef_slot(AXIS_Y, TERM_ROW), 32'sh0000_C000));
        send_paced(make_load(coef_slot(AXIS_Y, TERM_OFF), 32'sh0005_0000));
        send_paced(make_load(coef_slot(AXIS_Z, TERM_COL), 32'sh0000_1000));
        send_paced(make_load(coef_slot(AXIS_Z, TERM_ROW), -32'sh0000_2000));
        send_paced(make_load(coef_slot(AXIS_Z, TERM_OFF), 32'sh1234_5678));
        send_paced(make_pixel('0, '0, 8'h01, 1'b1));
        send_paced(make_pixel('1, '0, 8'h80, 1'b1));
        send_paced(make_pixel('0, '1, 8'hFE, 1'b1));
        // drive x into positive and y into negative saturation
        send_paced(make_load(coef_slot(AXIS_X, TERM_COL), POS_MAX));
        send_paced(make_load(coef_slot(AXIS_X, TERM_ROW), POS_MAX));
        send_paced(make_load(coef_slot(AXIS_X, TERM_OFF), POS_MAX));
        send_paced(make_load(coef_slot(AXIS_Y, TERM_COL), POS_MIN));
        send_paced(make_load(coef_slot(AXIS_Y, TERM_ROW), POS_MIN));
        send_paced(make_load(coef_slot(AXIS_Y, TERM_OFF), POS_MIN));
        send_paced(make_pixel('1, '1, 8'hFF, 1'b1));
        // masked pixel
        send_paced(make_pixel('1, '1, 8'hFF, 1'b0));
        // slots past the end change nothing
        send_paced(make_load(SLOT_W'(NUM_COEF), COEF_W'($urandom)));
        send_paced(make_load({SLOT_W{1'b1}}, COEF_W'($urandom)));
        send_paced(make_pixel('0, '0, 8'h00, 1'b1));
        send_paced(make_pixel(10'd512, 10'd513, 8'hAA, 1'b1));

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            no_stall = (n >= 120 && n < 180);
            if (n == 250)
            begin
                req_valid = 1'b0;
                while (board.pending() != 0)
                    @(negedge clk);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    r = make_load(SLOT_W'($urandom_range(NUM_COEF, 15)), pick_coef());
                else
                    r = make_load(SLOT_W'($urandom_range(0, NUM_COEF - 1)), pick_coef());
            end
            else
                r = make_pixel(pick_dim(), pick_dim(), LEVEL_W'($urandom),
                               $urandom_range(0, 6) != 0);
            send_paced(r);
        end
        req_valid = 1'b0;
        no_stall = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("masked_pixel_to_world_transform: match");
        else
            $display("masked_pixel_to_world_transform: mismatch");
        $finish;
    end
endmodule

// File: filelist.f
src/mpw_pkg.sv
src/mpw_front.sv
src/mpw_queue.sv
src/mpw_back.sv
src/masked_pixel_to_world_transform.sv
tb/masked_pixel_to_world_transform_test.sv
